FILE: design/read_alignment_statistics_defines.svh
// Assertion macros for the read alignment statistics block.
// Depends on nothing; included by files that carry assertions.
`ifndef READ_ALIGNMENT_STATISTICS_DEFINES_SVH
`define READ_ALIGNMENT_STATISTICS_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/ras_pkg.sv
// Package for the read alignment statistics block: types, sizes and codes.
// Depends on nothing.
package ras_pkg;
	localparam int LENGTH_BINS  = 1024;
	localparam int QUALITY_BINS = 256;
	localparam int EDIT_BINS    = 64;
	localparam int CLIP_BINS    = 1024;
	localparam int LEN_AW  = $clog2(LENGTH_BINS);
	localparam int QUAL_AW = $clog2(QUALITY_BINS);
	localparam int EDIT_AW = $clog2(EDIT_BINS);
	localparam int CLIP_AW = $clog2(CLIP_BINS);
	localparam int MAX_BINS = 1024;
	localparam int MAX_AW  = $clog2(MAX_BINS);
	localparam int QDEPTH  = 2;
	localparam int FLAG_UNMAPPED_BIT = 2;
	localparam int FLAG_REVERSE_BIT  = 4;
	localparam logic [3:0] OP_SOFT_CLIP = 4'd4;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_CIGAR  = 2'd1,
		KIND_END    = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SEL_LENGTH = 2'd0,
		SEL_QUAL   = 2'd1,
		SEL_EDIT   = 2'd2,
		SEL_CLIP   = 2'd3
	} hsel_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN
	} bstate_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] flags;
		logic [15:0] read_length;
		logic [7:0]  map_quality;
		logic [15:0] edit_distance;
		logic [3:0]  cigar_op;
		logic [27:0] cigar_len;
		logic [1:0]  hist_select;
		logic [9:0]  bin_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_count;
		logic [31:0] unmapped_count;
		logic [31:0] reverse_count;
		logic [15:0] max_length;
		logic [47:0] length_sum;
		logic [31:0] bin_count;
	} out_item_t;

	// Classified command passed from front to back: bin addresses are resolved.
	typedef struct packed {
		kind_t             kind;
		logic              unmapped;
		logic              reverse;
		logic [15:0]       read_length;
		logic [LEN_AW-1:0] len_bin;
		logic [QUAL_AW-1:0] qual_bin;
		logic [EDIT_AW-1:0] edit_bin;
		logic              soft_clip;
		logic [27:0]       cigar_len;
		hsel_t             sel;
		logic [MAX_AW-1:0] qaddr;
		logic              q_in_range;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage

FILE: design/read_alignment_statistics.sv
// Top level of the read alignment statistics block.
// Depends on ras_pkg, ras_front, ras_queue and ras_back.
//
// After reset the block sweeps its histogram memories to zero, holding busy high.
// Afterwards one command is accepted when start is high and busy is low; it passes
// through the queue, the back end's read stage and its update stage, and its result
// beat appears with done for one cycle. In the back end each command is read from
// memory, then updated and written; a new command is taken only after the previous
// one's update and write. Results cannot be stalled.
module read_alignment_statistics (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ras_pkg::in_item_t   in_item,
	output logic                done,
	output ras_pkg::out_item_t  result
);
	import ras_pkg::*;

	cmd_t   f_cmd, q_cmd;
	qstat_t qs;
	logic   pop, clearing, push;

	assign busy = clearing || qs.full;
	assign push = start && !busy;

	ras_front u_front (.in_item(in_item), .cmd(f_cmd));

	ras_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_cmd),
		.pop(pop), .rdata(q_cmd), .stat(qs)
	);

	ras_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!qs.empty), .cmd(q_cmd),
		.cmd_pop(pop), .clearing(clearing), .done(done), .result(result)
	);
endmodule

FILE: design/ras_front.sv
// Front end: accepts command beats and classifies them into bin addresses.
// Depends on ras_pkg.
module ras_front (
	input  ras_pkg::in_item_t in_item,
	output ras_pkg::cmd_t     cmd
);
	import ras_pkg::*;

	logic [9:0] bidx;

	always_comb begin
		bidx = in_item.bin_index;
		cmd.kind        = kind_t'(in_item.kind);
		cmd.unmapped    = in_item.flags[FLAG_UNMAPPED_BIT];
		cmd.reverse     = in_item.flags[FLAG_REVERSE_BIT];
		cmd.read_length = in_item.read_length;
		cmd.len_bin     = (32'(in_item.read_length) >= LENGTH_BINS) ?
			LEN_AW'(LENGTH_BINS - 1) : LEN_AW'(in_item.read_length);
		cmd.qual_bin    = (32'(in_item.map_quality) >= QUALITY_BINS) ?
			QUAL_AW'(QUALITY_BINS - 1) : QUAL_AW'(in_item.map_quality);
		cmd.edit_bin    = (32'(in_item.edit_distance) >= EDIT_BINS) ?
			EDIT_AW'(EDIT_BINS - 1) : EDIT_AW'(in_item.edit_distance);
		cmd.soft_clip   = (in_item.cigar_op == OP_SOFT_CLIP);
		cmd.cigar_len   = in_item.cigar_len;
		cmd.sel         = hsel_t'(in_item.hist_select);
		cmd.qaddr       = MAX_AW'(bidx);
		case (hsel_t'(in_item.hist_select))
			SEL_LENGTH: cmd.q_in_range = 32'(bidx) < LENGTH_BINS;
			SEL_QUAL:   cmd.q_in_range = 32'(bidx) < QUALITY_BINS;
			SEL_EDIT:   cmd.q_in_range = 32'(bidx) < EDIT_BINS;
			default:    cmd.q_in_range = 32'(bidx) < CLIP_BINS;
		endcase
	end
endmodule

FILE: design/ras_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on ras_pkg.
module ras_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ras_pkg::cmd_t  wdata,
	input  logic           pop,
	output ras_pkg::cmd_t  rdata,
	output ras_pkg::qstat_t stat
);
	import ras_pkg::*;

	cmd_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH):0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
endmodule

FILE: design/ras_back.sv
// Back end: clears the histograms after reset, then performs each command as a
// read, then a modify-write, and emits the result beat. Uses ras_pkg.
module ras_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  ras_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic              clearing,
	output logic              done,
	output ras_pkg::out_item_t result
);
	import ras_pkg::*;
	`include "read_alignment_statistics_defines.svh"

	bstate_t st_q, st_d;
	logic [MAX_AW-1:0] clr_q;
	logic clr_last;

	logic [31:0] len_mem  [LENGTH_BINS];
	logic [31:0] qual_mem [QUALITY_BINS];
	logic [31:0] edit_mem [EDIT_BINS];
	logic [31:0] clip_mem [CLIP_BINS];

	logic [31:0] total_q, unmap_q, rev_q, clipacc_q;
	logic [15:0] longest_q;
	logic [47:0] sum_q;
	logic        skip_q;
	logic [31:0] bin_q;

	// Stage 1: memory read, stage 2: update and write.
	logic        v_s1;
	cmd_t        c_s1;
	logic        skip_s1;
	logic [CLIP_AW-1:0] clip_bin_s1;
	logic [31:0] len_rd_s1, qual_rd_s1, edit_rd_s1, clip_rd_s1;

	logic [CLIP_AW-1:0] clip_bin;
	logic [32:0] acc_sum;
	logic [48:0] len_sum;
	logic        run;
	logic [31:0] qval;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_last) st_d = ST_RUN;
			ST_RUN:   st_d = ST_RUN;
			default:  st_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		run      = (st_q == ST_RUN);
		clearing = (st_q == ST_CLEAR);
		clr_last = (clr_q == MAX_AW'(MAX_BINS - 1));
		cmd_pop  = run && cmd_valid && !v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (clearing) clr_q <= clr_q + 1'b1;
		end
	end

	assign clip_bin = (clipacc_q >= 32'(CLIP_BINS)) ? CLIP_AW'(CLIP_BINS - 1) :
		CLIP_AW'(clipacc_q);

	// The pop cycle latches the command; an end item reads its clip bin now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= cmd_pop;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			c_s1        <= cmd;
			skip_s1     <= skip_q;
			clip_bin_s1 <= clip_bin;
			len_rd_s1   <= len_mem[(cmd.kind == KIND_QUERY) ?
				LEN_AW'(cmd.qaddr) : cmd.len_bin];
			qual_rd_s1  <= qual_mem[(cmd.kind == KIND_QUERY) ?
				QUAL_AW'(cmd.qaddr) : cmd.qual_bin];
			edit_rd_s1  <= edit_mem[(cmd.kind == KIND_QUERY) ?
				EDIT_AW'(cmd.qaddr) : cmd.edit_bin];
			clip_rd_s1  <= clip_mem[(cmd.kind == KIND_QUERY) ?
				CLIP_AW'(cmd.qaddr) : clip_bin];
		end
	end

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

	// Memory writes: a clearing sweep, then the updates of header and end commands.
	always_ff @(posedge clk) begin
		if (clearing) begin
			if (32'(clr_q) < LENGTH_BINS)  len_mem[LEN_AW'(clr_q)]   <= '0;
			if (32'(clr_q) < QUALITY_BINS) qual_mem[QUAL_AW'(clr_q)] <= '0;
			if (32'(clr_q) < EDIT_BINS)    edit_mem[EDIT_AW'(clr_q)] <= '0;
			if (32'(clr_q) < CLIP_BINS)    clip_mem[CLIP_AW'(clr_q)] <= '0;
		end else if (v_s1) begin
			if (c_s1.kind == KIND_HEADER) begin
				len_mem[c_s1.len_bin] <= sat_inc(len_rd_s1);
				if (!c_s1.unmapped) begin
					qual_mem[c_s1.qual_bin] <= sat_inc(qual_rd_s1);
					edit_mem[c_s1.edit_bin] <= sat_inc(edit_rd_s1);
				end
			end
			if (c_s1.kind == KIND_END && !skip_s1)
				clip_mem[clip_bin_s1] <= sat_inc(clip_rd_s1);
		end
	end

	assign acc_sum = 33'(clipacc_q) + 33'(c_s1.cigar_len);
	assign len_sum = 49'(sum_q) + 49'(c_s1.read_length);

	always_comb begin
		case (c_s1.sel)
			SEL_LENGTH: qval = len_rd_s1;
			SEL_QUAL:   qval = qual_rd_s1;
			SEL_EDIT:   qval = edit_rd_s1;
			default:    qval = clip_rd_s1;
		endcase
		if (!c_s1.q_in_range) qval = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			unmap_q   <= '0;
			rev_q     <= '0;
			longest_q <= '0;
			sum_q     <= '0;
			clipacc_q <= '0;
			skip_q    <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= v_s1;
			if (v_s1) begin
				case (c_s1.kind)
					KIND_HEADER: begin
						total_q <= sat_inc(total_q);
						if (c_s1.unmapped) unmap_q <= sat_inc(unmap_q);
						if (c_s1.reverse)  rev_q   <= sat_inc(rev_q);
						sum_q <= len_sum[48] ? '1 : len_sum[47:0];
						if (c_s1.read_length > longest_q) longest_q <= c_s1.read_length;
						clipacc_q <= '0;
						skip_q    <= c_s1.unmapped;
					end
					KIND_CIGAR: begin
						if (!skip_s1 && c_s1.soft_clip)
							clipacc_q <= acc_sum[32] ? '1 : acc_sum[31:0];
					end
					KIND_END: begin
						clipacc_q <= '0;
						skip_q    <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) bin_q <= (c_s1.kind == KIND_QUERY) ? qval : '0;
	end

	always_comb begin
		result.read_count     = total_q;
		result.unmapped_count = unmap_q;
		result.reverse_count  = rev_q;
		result.max_length     = longest_q;
		result.length_sum     = sum_q;
		result.bin_count      = bin_q;
	end

	`RAS_ASSERT_IMP(a_no_pop_clear, clk, arst_n, clearing, !cmd_pop)
	`RAS_ASSERT_NEXT(a_pop_stage, clk, arst_n, cmd_pop, v_s1)
	`RAS_ASSERT_NEXT(a_done_follows, clk, arst_n, v_s1, done)
	`RAS_ASSERT_IMP(a_no_overlap, clk, arst_n, v_s1, !cmd_pop)
endmodule
